// ===== rtl/asm_pkg.sv =====
// ----------------------------------------------------------------------------
// asm_pkg: shared types and helpers for the anchored string matcher
// Item types, configuration register indexes, pattern storage and
// ASCII case folding.
// ----------------------------------------------------------------------------
package asm_pkg;

	localparam int MAX_PATTERN_DEF = 16;
	localparam int PAT_BYTES       = 16;
	localparam int CNT_W           = 5;
	localparam int CFG_W           = 64;
	localparam int CFG_IDX_W       = 3;

	localparam logic [CNT_W-1:0] LEN_SAT = 5'd31;

	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ANCHOR_START    = 3'd0,
		CFG_ANCHOR_END      = 3'd1,
		CFG_SUBSEQ_MODE     = 3'd2,
		CFG_IGNORE_CASE     = 3'd3,
		CFG_PATTERN_LENGTH  = 3'd4,
		CFG_PATTERN_LOW     = 3'd5,
		CFG_PATTERN_HIGH    = 3'd6
	} cfg_idx_t;

	typedef logic [PAT_BYTES-1:0][7:0] pattern_t;

	typedef struct packed {
		logic [7:0] character;
		logic       last_char;
		logic       empty_string;
	} in_item_t;

	typedef struct packed {
		logic matched;
	} out_item_t;

	function automatic logic [7:0] fold(input logic [7:0] c, input logic ic);
		logic [7:0] r;
		r = c;
		if (ic && (c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) begin
			r = c - CH_UPPER_A + CH_LOWER_A;
		end
		return r;
	endfunction

endpackage

// ===== rtl/asm_stream_if.sv =====
// ----------------------------------------------------------------------------
// asm_stream_if: valid/ready request channel
// Carries one payload of type T per accepted request.
// ----------------------------------------------------------------------------
interface asm_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/asm_window.sv =====
// ----------------------------------------------------------------------------
// asm_window: recent byte window and tail comparator
// Shifts in one byte per request and compares the newest bytes, as they
// stand after the shift, against the pattern in parallel.
// ----------------------------------------------------------------------------
module asm_window #(
	parameter int DEPTH = asm_pkg::MAX_PATTERN_DEF
) (
	input  logic                       clk,
	input  logic                       shift,
	input  logic [7:0]                 character,
	input  logic                       ignore_case,
	input  asm_pkg::pattern_t          pattern,
	input  logic [asm_pkg::CNT_W-1:0]  len,
	input  logic [asm_pkg::CNT_W-1:0]  count_next,
	output logic                       tail_hit
);
	import asm_pkg::*;

	logic [DEPTH-1:0][7:0] win_q;
	logic [DEPTH-1:0][7:0] win_next;
	logic [DEPTH-1:0]      pos_ok;

	always_comb begin
		win_next[0] = character;
		for (int j = 1; j < DEPTH; j++) begin
			win_next[j] = win_q[j-1];
		end
	end

	// Window entry j pairs with pattern byte len-1-j; entries past len are don't-care.
	always_comb begin
		logic [CNT_W-1:0] p;
		for (int j = 0; j < DEPTH; j++) begin
			p = len - CNT_W'(1) - CNT_W'(j);
			pos_ok[j] = (CNT_W'(j) >= len) ||
				(fold(win_next[j], ignore_case) == fold(pattern[p[3:0]], ignore_case));
		end
	end

	assign tail_hit = (count_next >= len) && (&pos_ok);

	always_ff @(posedge clk) begin
		if (shift) begin
			win_q <= win_next;
		end
	end

endmodule

// ===== rtl/anchored_substring_subsequence_match.sv =====
// ----------------------------------------------------------------------------
// anchored_substring_subsequence_match: streaming string pattern matcher
// Matches each input string against a pattern of up to MAX_PATTERN bytes,
// as a contiguous substring or an ordered subsequence, with optional
// start and end anchors and ASCII case folding. One result per string.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                  | handshake
//  ---------+-----+------------------------------------------+-------------
//  in_ch    | in  | character[8], last_char, empty_string    | valid/ready
//  out_ch   | out | matched                                  | valid/ready
//  cfg      | in  | cfg_index[3], cfg_data[64]               | cfg_we only
//
//  One request per cycle sustained unless a stalled result holds back a
//  request that ends a string; the result register loads when such a request
//  leaves the input register, after one pass of comparators.
//  The window comparators and the per-byte pattern lookups set the path.
//  Reset clears all control state and configuration; no clearing pass.
//  A stalled result blocks only requests that end a string; bytes inside
//  a string keep flowing.
// ----------------------------------------------------------------------------
module anchored_substring_subsequence_match #(
	parameter int MAX_PATTERN = asm_pkg::MAX_PATTERN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	asm_stream_if.sink                    in_ch,
	asm_stream_if.source                  out_ch,
	input  logic                          cfg_we,
	input  logic [asm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [asm_pkg::CFG_W-1:0]     cfg_data
);
	import asm_pkg::*;

	// configuration
	logic             anchor_start_q, anchor_end_q, subseq_mode_q, ignore_case_q;
	logic [CNT_W-1:0] pattern_length_q;
	logic [63:0]      pattern_low_q, pattern_high_q;
	pattern_t         pattern;
	logic [CNT_W-1:0] len;

	// input stage
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1, empty_s1;

	// per-string state
	logic [CNT_W-1:0] bytes_seen_q, subseq_q;
	logic             start_failed_q, found_q, end_hit_q, first_mm_q;

	logic [CNT_W-1:0] bytes_seen_n, subseq_n;
	logic             start_failed_n, found_n, end_hit_n, first_mm_n;
	logic             tail_hit, result, emits, adv;
	logic [7:0]       fc;

	logic out_valid_q, matched_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_start_q   <= 1'b0;
			anchor_end_q     <= 1'b0;
			subseq_mode_q    <= 1'b0;
			ignore_case_q    <= 1'b0;
			pattern_length_q <= '0;
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ANCHOR_START:   anchor_start_q   <= cfg_data[0];
				CFG_ANCHOR_END:     anchor_end_q     <= cfg_data[0];
				CFG_SUBSEQ_MODE:    subseq_mode_q    <= cfg_data[0];
				CFG_IGNORE_CASE:    ignore_case_q    <= cfg_data[0];
				CFG_PATTERN_LENGTH: pattern_length_q <= cfg_data[CNT_W-1:0];
				CFG_PATTERN_LOW:    pattern_low_q    <= cfg_data;
				CFG_PATTERN_HIGH:   pattern_high_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign pattern = pattern_t'({pattern_high_q, pattern_low_q});
	assign len = (pattern_length_q > CNT_W'(MAX_PATTERN)) ? CNT_W'(MAX_PATTERN)
		: pattern_length_q;

	// handshake
	assign emits       = last_s1 || empty_s1;
	assign adv         = valid_s1 && (!emits || !out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			char_s1  <= in_ch.data.character;
			last_s1  <= in_ch.data.last_char;
			empty_s1 <= in_ch.data.empty_string;
		end
	end

	asm_window #(
		.DEPTH(MAX_PATTERN)
	) u_window (
		.clk        (clk),
		.shift      (adv && !empty_s1),
		.character  (char_s1),
		.ignore_case(ignore_case_q),
		.pattern    (pattern),
		.len        (len),
		.count_next (bytes_seen_n),
		.tail_hit   (tail_hit)
	);

	// next state for a byte request
	always_comb begin
		fc = fold(char_s1, ignore_case_q);
		bytes_seen_n = (bytes_seen_q == LEN_SAT) ? LEN_SAT : bytes_seen_q + CNT_W'(1);
		start_failed_n = start_failed_q ||
			((bytes_seen_q < len) && (fc != fold(pattern[bytes_seen_q[3:0]], ignore_case_q)));
		first_mm_n = first_mm_q ||
			((bytes_seen_q == '0) && (fc != fold(pattern[0], ignore_case_q)));
		subseq_n  = subseq_q;
		end_hit_n = 1'b0;
		if ((subseq_q < len) && (fc == fold(pattern[subseq_q[3:0]], ignore_case_q))) begin
			subseq_n  = subseq_q + CNT_W'(1);
			end_hit_n = (subseq_n == len);
		end
		found_n = found_q || ((len != '0) && tail_hit);

		// decision at the end of a string
		if (empty_s1) begin
			result = !subseq_mode_q && (len == '0);
		end else if (subseq_mode_q) begin
			result = (bytes_seen_n != '0) && (len != '0) && (subseq_n == len) &&
				!(anchor_start_q && first_mm_n) && !(anchor_end_q && !end_hit_n);
		end else if (len == '0) begin
			result = 1'b1;
		end else if (anchor_start_q && anchor_end_q) begin
			result = (bytes_seen_n == len) && !start_failed_n;
		end else if (anchor_start_q) begin
			result = (bytes_seen_n >= len) && !start_failed_n;
		end else if (anchor_end_q) begin
			result = tail_hit;
		end else begin
			result = found_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_seen_q   <= '0;
			subseq_q       <= '0;
			start_failed_q <= 1'b0;
			found_q        <= 1'b0;
			end_hit_q      <= 1'b0;
			first_mm_q     <= 1'b0;
		end else if (adv) begin
			if (emits) begin
				// drop the finished string
				bytes_seen_q   <= '0;
				subseq_q       <= '0;
				start_failed_q <= 1'b0;
				found_q        <= 1'b0;
				end_hit_q      <= 1'b0;
				first_mm_q     <= 1'b0;
			end else begin
				bytes_seen_q   <= bytes_seen_n;
				subseq_q       <= subseq_n;
				start_failed_q <= start_failed_n;
				found_q        <= found_n;
				end_hit_q      <= end_hit_n;
				first_mm_q     <= first_mm_n;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && emits) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emits) begin
			matched_q <= result;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.data.matched = matched_q;

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && emits |=> (bytes_seen_q == '0) && (subseq_q == '0) && !found_q)
		else $error("string state not cleared after end of string");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		adv && emits |=> out_valid_q)
		else $error("result lost at end of string");

	a_subseq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		subseq_q <= CNT_W'(MAX_PATTERN))
		else $error("subsequence pointer beyond pattern");

	a_hit_needs_progress: assert property (@(posedge clk) disable iff (!arst_n)
		end_hit_q |-> (subseq_q != '0))
		else $error("end hit without subsequence progress");

	a_empty_string_state: assert property (@(posedge clk) disable iff (!arst_n)
		(bytes_seen_q == '0) |-> !found_q && !start_failed_q && (subseq_q == '0))
		else $error("flags set with no bytes seen");

endmodule
